[design/cdec_pkg.sv]
package cdec_pkg;

   localparam int MAX_CLASSES = 8192;
   localparam int MAX_STEPS   = 64;

   localparam int SCORE_W = 16;
   localparam int CLASS_W = $clog2(MAX_CLASSES);
   localparam int CNT_W   = $clog2(MAX_STEPS + 1);
   localparam int SUM_W   = SCORE_W + $clog2(MAX_STEPS + 1);
   localparam int INDEX_W = 13;
   localparam int DICT_W  = 13;
   localparam int TOTAL_W = 7;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(MAX_CLASSES - 1);
   localparam logic [CNT_W-1:0]   STEPS_MAX  = CNT_W'(MAX_STEPS);

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_char;
      logic load_summary;
      logic div_start;
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic div_done;
   } status_type;

endpackage

[design/cdec_divider.sv]
module cdec_divider
   import cdec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   dividend,
   input  logic [CNT_W-1:0]   divisor,
   output logic               done,
   output logic [SCORE_W-1:0] quotient
);

   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [CNT_W:0]       trial;
   logic [CNT_W:0]       diff;

   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      diff   = trial - {1'b0, div_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = DIV_CNT_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = !busy_ff;
   assign quotient = (div_ff == '0) ? '0 : quo_ff[SCORE_W-1:0];

endmodule

[design/cdec_datapath.sv]
module cdec_datapath
   import cdec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_write_enable,
   input  logic [DICT_W-1:0]  csr_write_data,
   input  logic [SCORE_W-1:0] req_score,
   input  logic               req_step_end,
   output logic               rsp_kind,
   output logic [INDEX_W-1:0] rsp_char_index,
   output logic               rsp_in_dictionary,
   output logic [SCORE_W-1:0] rsp_char_score,
   output logic [SCORE_W-1:0] rsp_avg_confidence,
   output logic [TOTAL_W-1:0] rsp_char_total,
   output logic               rsp_last
);

   logic [DICT_W-1:0]  dict_ff;
   logic [CLASS_W-1:0] class_ff, class_in;
   logic [SCORE_W-1:0] best_ff, best_in;
   logic [CLASS_W-1:0] best_class_ff, best_class_in;
   logic [CLASS_W-1:0] prev_ff, prev_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               take;
   logic               keep;
   logic               div_done;
   logic [SCORE_W-1:0] win_score;
   logic [CLASS_W-1:0] win_class;
   logic [INDEX_W-1:0] win_index;
   logic [CNT_W-1:0]   count_inc;
   logic [SCORE_W-1:0] quotient;

   logic               kind_ff;
   logic [INDEX_W-1:0] index_ff;
   logic               indict_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [SCORE_W-1:0] avg_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic               last_ff;

   cdec_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status = '{keep: keep, div_done: div_done};

   always_comb begin
      take      = (class_ff == '0) || (req_score > best_ff);
      win_score = take ? req_score : best_ff;
      win_class = take ? class_ff : best_class_ff;
      win_index = INDEX_W'(win_class - 1'b1);
      count_inc = count_ff + 1'b1;
      keep      = (win_class != '0) && (win_class != prev_ff) && (count_ff < STEPS_MAX);

      class_in      = class_ff;
      best_in       = best_ff;
      best_class_in = best_class_ff;
      prev_in       = prev_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      if (cmd.accept) begin
         if (req_step_end) begin
            class_in      = '0;
            best_in       = '0;
            best_class_in = '0;
            prev_in       = win_class;
            if (keep) begin
               sum_in   = sum_ff + SUM_W'(win_score);
               count_in = count_inc;
            end
         end else begin
            best_in       = win_score;
            best_class_in = win_class;
            if (class_ff != CLASS_LAST) begin
               class_in = class_ff + 1'b1;
            end
         end
      end
      if (cmd.load_summary) begin
         prev_in  = '0;
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dict_ff       <= '0;
         class_ff      <= '0;
         best_ff       <= '0;
         best_class_ff <= '0;
         prev_ff       <= '0;
         sum_ff        <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            dict_ff <= csr_write_data;
         end
         class_ff      <= class_in;
         best_ff       <= best_in;
         best_class_ff <= best_class_in;
         prev_ff       <= prev_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         kind_ff   <= KIND_CHAR;
         index_ff  <= win_index;
         indict_ff <= (DICT_W'(win_index) < dict_ff);
         score_ff  <= win_score;
         avg_ff    <= '0;
         total_ff  <= TOTAL_W'(count_inc);
         last_ff   <= 1'b0;
      end else if (cmd.load_summary) begin
         kind_ff   <= KIND_SUMMARY;
         index_ff  <= '0;
         indict_ff <= 1'b0;
         score_ff  <= '0;
         avg_ff    <= quotient;
         total_ff  <= TOTAL_W'(count_ff);
         last_ff   <= 1'b1;
      end
   end

   assign rsp_kind           = kind_ff;
   assign rsp_char_index     = index_ff;
   assign rsp_in_dictionary  = indict_ff;
   assign rsp_char_score     = score_ff;
   assign rsp_avg_confidence = avg_ff;
   assign rsp_char_total     = total_ff;
   assign rsp_last           = last_ff;

endmodule

[design/cdec_controller.sv]
module cdec_controller
   import cdec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_step_end,
   input  logic       req_sequence_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      req_ready = (state_ff == ST_RUN) && out_free;
      cmd       = '0;
      cmd.accept = req_valid && req_ready;
      state_in  = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (cmd.accept && req_step_end) begin
               cmd.load_char = status.keep;
               if (req_sequence_end) begin
                  state_in = ST_DIV_LOAD;
               end
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               cmd.load_summary = 1'b1;
               state_in         = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
      if (cmd.load_char || cmd.load_summary) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[design/ctc_greedy_decoder.sv]
// Channel  Handshake              Payload
// req      req_valid/req_ready    score, step_end, sequence_end
// rsp      rsp_valid/rsp_ready    kind, char_index, in_dictionary, char_score,
//                                 avg_confidence, char_total, last
// csr      csr_write_enable       csr_write_data (dictionary entry count)
//
// One score item a cycle while the output register is free or being taken.
// A sequence end holds the input through the divider load, divide and summary states plus any wait on the output:
// the average comes from a radix-2 divider, one quotient bit a cycle (23 bits).
// Synchronous active-high reset; no clearing pass, ready the cycle after.
// A stalled result holds in the output register and stalls the input.
module ctc_greedy_decoder
   import cdec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SCORE_W-1:0] req_score,
   input  logic               req_step_end,
   input  logic               req_sequence_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [INDEX_W-1:0] rsp_char_index,
   output logic               rsp_in_dictionary,
   output logic [SCORE_W-1:0] rsp_char_score,
   output logic [SCORE_W-1:0] rsp_avg_confidence,
   output logic [TOTAL_W-1:0] rsp_char_total,
   output logic               rsp_last,
   input  logic               csr_write_enable,
   input  logic [DICT_W-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   cdec_controller u_controller (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step_end     (req_step_end),
      .req_sequence_end (req_sequence_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .status           (status),
      .cmd              (cmd)
   );

   cdec_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_score          (req_score),
      .req_step_end       (req_step_end),
      .rsp_kind           (rsp_kind),
      .rsp_char_index     (rsp_char_index),
      .rsp_in_dictionary  (rsp_in_dictionary),
      .rsp_char_score     (rsp_char_score),
      .rsp_avg_confidence (rsp_avg_confidence),
      .rsp_char_total     (rsp_char_total),
      .rsp_last           (rsp_last)
   );

endmodule
